/* rtl/cn_pkg.sv */
// Package for the chromaticity normalizer: beat structs, widths and the
// inter-cell bus type. No dependencies.
package cn_pkg;

  localparam int unsigned CHAN_W  = 8;              // channel and quotient width
  localparam int unsigned SUM_W   = 10;             // a + b + c, 0..765
  localparam int unsigned PROD_W  = 16;             // 255 * chan, 0..65025
  localparam int unsigned CMP_W   = SUM_W + CHAN_W; // sum shifted by up to 7
  localparam int unsigned N_CHAN  = 3;
  localparam int unsigned N_CELLS = CHAN_W;         // one quotient bit per cell

  typedef struct packed {
    logic [CHAN_W-1:0] chan_a;
    logic [CHAN_W-1:0] chan_b;
    logic [CHAN_W-1:0] chan_c;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] norm_a;
    logic [CHAN_W-1:0] norm_b;
    logic [CHAN_W-1:0] norm_c;
  } result_t;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic                           valid;
    logic                           zero;   // black pixel, force result to 0
    logic [SUM_W-1:0]               sum;
    logic [N_CHAN-1:0][PROD_W-1:0]  rem;
    logic [N_CHAN-1:0][CHAN_W-1:0]  quo;
  } cell_bus_t;

endpackage

/* rtl/cn_front.sv */
// Front stage: channel sum and 255*chan products, registered.
// Depends on cn_pkg.
module cn_front
  import cn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  pixel_t    pixel,
  output cell_bus_t bus
);

  logic [CHAN_W-1:0] chan [N_CHAN];
  logic [SUM_W-1:0]  sum_next;

  assign chan[0] = pixel.chan_a;
  assign chan[1] = pixel.chan_b;
  assign chan[2] = pixel.chan_c;

  assign sum_next = SUM_W'(chan[0]) + SUM_W'(chan[1]) + SUM_W'(chan[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      bus.valid <= 1'b0;
    end else begin
      bus.valid <= start;
    end
    bus.sum  <= sum_next;
    bus.zero <= (sum_next == '0);
    for (int i = 0; i < N_CHAN; i++) begin
      // 255*c = (c << 8) - c
      bus.rem[i] <= {chan[i], {CHAN_W{1'b0}}} - PROD_W'(chan[i]);
      bus.quo[i] <= '0;
    end
  end

endmodule

/* rtl/cn_div_cell.sv */
// One restoring-division cell: resolves quotient bit BIT for all three lanes.
// Depends on cn_pkg.
module cn_div_cell
  import cn_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_bus_t bus_in,
  output cell_bus_t bus_out
);

  logic [CMP_W-1:0]  div_shift;
  logic [CMP_W-1:0]  rem_ext  [N_CHAN];
  logic [CMP_W-1:0]  diff     [N_CHAN];
  logic              take     [N_CHAN];
  logic [CHAN_W-1:0] quo_next [N_CHAN];

  assign div_shift = CMP_W'(bus_in.sum) << BIT;

  always_comb begin
    for (int i = 0; i < N_CHAN; i++) begin
      rem_ext[i]       = CMP_W'(bus_in.rem[i]);
      take[i]          = (rem_ext[i] >= div_shift);
      diff[i]          = rem_ext[i] - div_shift;
      quo_next[i]      = bus_in.quo[i];
      quo_next[i][BIT] = take[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_out.valid <= 1'b0;
    end else begin
      bus_out.valid <= bus_in.valid;
    end
    bus_out.zero <= bus_in.zero;
    bus_out.sum  <= bus_in.sum;
    for (int i = 0; i < N_CHAN; i++) begin
      bus_out.rem[i] <= take[i] ? diff[i][PROD_W-1:0] : bus_in.rem[i];
      bus_out.quo[i] <= quo_next[i];
    end
  end

endmodule

/* rtl/chromaticity_normalize.sv */
// Top level of the normalized RGB chromaticity block.
// Depends on cn_pkg, cn_front and cn_div_cell.
//
// Takes one 8-bit three-channel pixel per clock and returns
// norm = floor(255 * chan / (a + b + c)) for each channel, with all
// outputs 0 for a black pixel. A pixel beat is taken whenever start is
// high; busy is always low, so a new pixel may enter every cycle. Each
// result appears on result for one cycle with done high, after passing
// through the front stage, eight divider cells and the output register,
// in pixel order. The receiver cannot stall; it must take every result
// beat as it shows. Throughput is one pixel per clock; the pipeline is
// a chain of eight cells, each resolving one quotient bit for all three
// channels. No state is kept between pixels.
module chromaticity_normalize
  import cn_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  pixel_t  pixel,
  output logic    done,
  output result_t result
);

  // bus[0] leaves the front stage, bus[N_CELLS] leaves the last cell
  cell_bus_t bus [N_CELLS+1];

  assign busy = 1'b0;

  cn_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .pixel (pixel),
    .bus   (bus[0])
  );

  // MSB first: cell k resolves quotient bit CHAN_W-1-k
  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    cn_div_cell #(
      .BIT (CHAN_W - 1 - k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .bus_in  (bus[k]),
      .bus_out (bus[k+1])
    );
  end

  // Output register; black pixel overrides the quotient.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= bus[N_CELLS].valid;
    end
    result.norm_a <= bus[N_CELLS].zero ? '0 : bus[N_CELLS].quo[0];
    result.norm_b <= bus[N_CELLS].zero ? '0 : bus[N_CELLS].quo[1];
    result.norm_c <= bus[N_CELLS].zero ? '0 : bus[N_CELLS].quo[2];
  end

endmodule

/* verif/tb_chromaticity_normalize.sv */
// Self-checking testbench for chromaticity_normalize: drives pixel beats and
// checks each normalized result against a built-in integer model.
// Depends on cn_pkg and the chromaticity_normalize RTL.
module tb_chromaticity_normalize;
  import cn_pkg::*;

  // Tracks pixels taken by the block and checks the chromaticity beats that
  // come back, oldest first.
  class chroma_tracker;
    result_t     norm_due[$];
    int unsigned errors;
    int unsigned pixels_taken;
    int unsigned results_seen;
    int unsigned black_seen;

    function new();
      errors       = 0;
      pixels_taken = 0;
      results_seen = 0;
      black_seen   = 0;
    endfunction

    // floor(255 * chan / sum) for each channel; a black pixel gives all zero.
    function result_t chroma_of(pixel_t p);
      result_t           r;
      logic [SUM_W-1:0]  sum;
      logic [PROD_W-1:0] prod;
      sum = {2'b00, p.chan_a} + {2'b00, p.chan_b} + {2'b00, p.chan_c};
      r = '0;
      if (sum != 0) begin
        prod = 16'd255 * p.chan_a;
        r.norm_a = CHAN_W'(prod / sum);
        prod = 16'd255 * p.chan_b;
        r.norm_b = CHAN_W'(prod / sum);
        prod = 16'd255 * p.chan_c;
        r.norm_c = CHAN_W'(prod / sum);
      end
      return r;
    endfunction

    function void take_pixel(pixel_t p);
      pixels_taken++;
      if (p == '0) black_seen++;
      norm_due.push_back(chroma_of(p));
    endfunction

    function void match_result(result_t got);
      result_t want;
      results_seen++;
      if (norm_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending: got a=%0d b=%0d c=%0d",
                 $time, got.norm_a, got.norm_b, got.norm_c);
        return;
      end
      want = norm_due.pop_front();
      if (got.norm_a !== want.norm_a) begin
        errors++;
        $display("%0t: norm_a mismatch: expected %0d, got %0d",
                 $time, want.norm_a, got.norm_a);
      end
      if (got.norm_b !== want.norm_b) begin
        errors++;
        $display("%0t: norm_b mismatch: expected %0d, got %0d",
                 $time, want.norm_b, got.norm_b);
      end
      if (got.norm_c !== want.norm_c) begin
        errors++;
        $display("%0t: norm_c mismatch: expected %0d, got %0d",
                 $time, want.norm_c, got.norm_c);
      end
    endfunction

    function int unsigned pending();
      return norm_due.size();
    endfunction

    // Anything still queued at the end never came out of the block.
    function void close_out();
      if (norm_due.size() != 0) begin
        errors += norm_due.size();
        $display("%0t: %0d expected result beats never arrived",
                 $time, norm_due.size());
      end
    endfunction
  endclass

  localparam int unsigned RAND_PER_PHASE = 610;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned DRAIN_LIMIT    = 1000;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  pixel_t  pixel = '0;
  logic    busy;
  logic    done;
  result_t result;

  chroma_tracker tracker = new();

  chromaticity_normalize i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .pixel  (pixel),
    .done   (done),
    .result (result)
  );

  always #2 clk = ~clk;

  // Monitors sample at the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (!rst && start && !busy) tracker.take_pixel(pixel);
    if (!rst && done) tracker.match_result(result);
  end

  // One pixel beat, preceded by a random number of idle cycles.
  task automatic send_pixel(input pixel_t p, input int unsigned gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold off until every pending result has come out.
  task automatic wait_drained();
    int unsigned n;
    n = 0;
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
  endtask

  function automatic pixel_t make_pixel(int unsigned a, int unsigned b, int unsigned c);
    pixel_t p;
    p.chan_a = CHAN_W'(a);
    p.chan_b = CHAN_W'(b);
    p.chan_c = CHAN_W'(c);
    return p;
  endfunction

  // Mostly full-range pixels, with black, single-channel, very dark and very
  // bright pixels mixed in since those hit the zero and full-scale corners.
  function automatic pixel_t rand_pixel();
    pixel_t      p;
    int unsigned kind;
    kind = $urandom_range(99);
    p = make_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    if (kind < 5) begin
      p = '0;
    end else if (kind < 15) begin
      case ($urandom_range(2))
        0: begin p.chan_b = '0; p.chan_c = '0; end
        1: begin p.chan_a = '0; p.chan_c = '0; end
        default: begin p.chan_a = '0; p.chan_b = '0; end
      endcase
    end else if (kind < 30) begin
      p = make_pixel($urandom_range(3), $urandom_range(3), $urandom_range(3));
    end else if (kind < 38) begin
      p = make_pixel($urandom_range(255, 240), $urandom_range(255, 240),
                     $urandom_range(255, 240));
    end
    return p;
  endfunction

  pixel_t      directed[$];
  int unsigned gap_plan[3] = '{30, 59, 0};

  initial begin
    directed = '{
      make_pixel(0, 0, 0),       make_pixel(255, 255, 255), make_pixel(255, 0, 0),
      make_pixel(0, 255, 0),     make_pixel(0, 0, 255),     make_pixel(1, 0, 0),
      make_pixel(0, 1, 0),       make_pixel(0, 0, 1),       make_pixel(1, 1, 1),
      make_pixel(255, 255, 0),   make_pixel(0, 255, 255),   make_pixel(255, 0, 255),
      make_pixel(1, 254, 255),   make_pixel(254, 1, 0),     make_pixel(128, 64, 32),
      make_pixel(85, 170, 85),   make_pixel(170, 85, 170),  make_pixel(2, 1, 0),
      make_pixel(1, 2, 255),     make_pixel(3, 3, 3),       make_pixel(127, 128, 0),
      make_pixel(0, 0, 0)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_pixel(directed[i], 0);
    wait_drained();

    // Three idling regimes; each ends with a full drain before the next.
    foreach (gap_plan[ph]) begin
      for (int unsigned i = 0; i < RAND_PER_PHASE; i++)
        send_pixel(rand_pixel(), gap_plan[ph]);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    tracker.close_out();

    $display("Sent %0d pixels (%0d black) across directed, idle-heavy and back-to-back runs;",
             tracker.pixels_taken, tracker.black_seen);
    $display("checked %0d normalized result beats, %0d errors.",
             tracker.results_seen, tracker.errors);
    if (tracker.errors == 0) begin
      $display("tb_chromaticity_normalize OK");
    end else begin
      $display("tb_chromaticity_normalize NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("tb_chromaticity_normalize NOT OK");
    $finish;
  end

endmodule
